@@ src/tcps_pkg.sv @@
`timescale 1ns / 1ps

package tcps_pkg;

	localparam logic [1:0] KIND_IDLE = 2'd0;
	localparam logic [1:0] KIND_HIGH = 2'd1;
	localparam logic [1:0] KIND_LOW  = 2'd2;

	localparam logic [31:0] SAT_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [31:0] ts;
		logic [31:0] id;
	} entry_t;

	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? SAT_MAX : s[31:0];
	endfunction

endpackage

@@ src/two_class_priority_scheduler.sv @@
`timescale 1ns / 1ps

// Two-class strict-priority scheduler with tail drop. Each word taken on start is one
// time tick: its arrivals are queued (high class first) and one request is served.
// busy is always low, so a word may be started in every cycle; one result per word is
// shown on the result ports for exactly one cycle, marked by done, after the word has
// passed the input stage and the result register. The receiver cannot stall the
// block, so results must be captured whenever done is high. The statistics counters
// saturate at 2^32-1.
module two_class_priority_scheduler #(
	parameter int QUEUE_DEPTH  = 4,
	parameter int MAX_ARRIVALS = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  high_arrivals,
	input  logic [2:0]  low_arrivals,
	output logic        done,
	output logic [1:0]  served_kind,
	output logic [31:0] served_id,
	output logic [31:0] served_wait,
	output logic [31:0] total_requests,
	output logic [31:0] high_served_count,
	output logic [31:0] low_served_count,
	output logic [31:0] refused_count,
	output logic [31:0] idle_count,
	output logic [31:0] high_wait_sum,
	output logic [31:0] low_wait_sum,
	output logic [2:0]  high_queued,
	output logic [2:0]  low_queued
);

	import tcps_pkg::*;

	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FW = $clog2(QUEUE_DEPTH + 1);
	localparam int AW = $clog2(2 * QUEUE_DEPTH + 16);
	localparam logic [AW-1:0] DEPTH_A = AW'(QUEUE_DEPTH);
	localparam logic [AW-1:0] MAXA_A  = AW'(MAX_ARRIVALS);

	// input stage
	logic       valid_s1;
	logic [2:0] high_arr_s1;
	logic [2:0] low_arr_s1;

	// queue state
	entry_t          high_fifo_q [QUEUE_DEPTH];
	entry_t          low_fifo_q  [QUEUE_DEPTH];
	logic [IW-1:0]   high_head_q, low_head_q;
	logic [FW-1:0]   high_fill_q, low_fill_q;
	logic [31:0]     tick_q, req_q;
	logic [31:0]     high_srv_q, low_srv_q, refused_q, idle_q, high_wsum_q, low_wsum_q;

	// result register
	logic        done_q;
	logic [1:0]  kind_q;
	logic [31:0] id_q, wait_q;
	logic [2:0]  high_queued_q, low_queued_q;

	// tick logic
	logic [AW-1:0]   nh, nl, acc_h, acc_l, room_h, room_l;
	logic [AW-1:0]   pos_h, pos_l, tail_h, tail_l, hf_after, lf_after;
	logic [31:0]     tick_new, req_new, refused_inc;
	logic            we_h [QUEUE_DEPTH];
	logic            we_l [QUEUE_DEPTH];
	entry_t          wr_h [QUEUE_DEPTH];
	entry_t          wr_l [QUEUE_DEPTH];
	entry_t          head_e;
	logic [1:0]      kind_d;
	logic [31:0]     id_d, wait_d;
	logic [IW-1:0]   high_head_d, low_head_d;
	logic [FW-1:0]   high_fill_d, low_fill_d;

	assign busy = 1'b0;

	always_comb begin
		logic [AW-1:0] off;
		nh = (AW'(high_arr_s1) > MAXA_A) ? MAXA_A : AW'(high_arr_s1);
		nl = (AW'(low_arr_s1) > MAXA_A) ? MAXA_A : AW'(low_arr_s1);
		room_h = DEPTH_A - AW'(high_fill_q);
		room_l = DEPTH_A - AW'(low_fill_q);
		acc_h = (nh < room_h) ? nh : room_h;
		acc_l = (nl < room_l) ? nl : room_l;
		pos_h = AW'(high_head_q) + AW'(high_fill_q);
		pos_l = AW'(low_head_q) + AW'(low_fill_q);
		tail_h = (pos_h >= DEPTH_A) ? pos_h - DEPTH_A : pos_h;
		tail_l = (pos_l >= DEPTH_A) ? pos_l - DEPTH_A : pos_l;
		tick_new = sat_add32(tick_q, 32'd1);
		req_new = sat_add32(req_q, 32'(nh) + 32'(nl));
		refused_inc = 32'(nh - acc_h) + 32'(nl - acc_l);
		hf_after = AW'(high_fill_q) + acc_h;
		lf_after = AW'(low_fill_q) + acc_l;

		for (int j = 0; j < QUEUE_DEPTH; j++) begin
			off = (AW'(j) >= tail_h) ? AW'(j) - tail_h : AW'(j) + DEPTH_A - tail_h;
			we_h[j] = off < acc_h;
			wr_h[j].ts = tick_new;
			wr_h[j].id = sat_add32(req_q, 32'(off) + 32'd1);
			off = (AW'(j) >= tail_l) ? AW'(j) - tail_l : AW'(j) + DEPTH_A - tail_l;
			we_l[j] = off < acc_l;
			wr_l[j].ts = tick_new;
			wr_l[j].id = sat_add32(req_q, 32'(nh) + 32'(off) + 32'd1);
		end

		head_e = '0;
		kind_d = KIND_IDLE;
		high_head_d = high_head_q;
		low_head_d = low_head_q;
		high_fill_d = FW'(hf_after);
		low_fill_d = FW'(lf_after);
		if (hf_after != '0) begin
			kind_d = KIND_HIGH;
			if (high_fill_q != '0) begin
				head_e = high_fifo_q[high_head_q];
			end else begin
				head_e.ts = tick_new;
				head_e.id = sat_add32(req_q, 32'd1);
			end
			high_head_d = (AW'(high_head_q) == DEPTH_A - AW'(1)) ? '0 : high_head_q + IW'(1);
			high_fill_d = FW'(hf_after - AW'(1));
		end else if (lf_after != '0) begin
			kind_d = KIND_LOW;
			if (low_fill_q != '0) begin
				head_e = low_fifo_q[low_head_q];
			end else begin
				head_e.ts = tick_new;
				head_e.id = sat_add32(req_q, 32'(nh) + 32'd1);
			end
			low_head_d = (AW'(low_head_q) == DEPTH_A - AW'(1)) ? '0 : low_head_q + IW'(1);
			low_fill_d = FW'(lf_after - AW'(1));
		end
		id_d = (kind_d == KIND_IDLE) ? 32'd0 : head_e.id;
		wait_d = (kind_d == KIND_IDLE) ? 32'd0 : tick_new - head_e.ts;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			high_arr_s1 <= high_arrivals;
			low_arr_s1 <= low_arrivals;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			for (int j = 0; j < QUEUE_DEPTH; j++) begin
				if (we_h[j]) begin
					high_fifo_q[j] <= wr_h[j];
				end
				if (we_l[j]) begin
					low_fifo_q[j] <= wr_l[j];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_head_q <= '0;
			low_head_q <= '0;
			high_fill_q <= '0;
			low_fill_q <= '0;
			tick_q <= '0;
			req_q <= '0;
			high_srv_q <= '0;
			low_srv_q <= '0;
			refused_q <= '0;
			idle_q <= '0;
			high_wsum_q <= '0;
			low_wsum_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
			if (valid_s1) begin
				high_head_q <= high_head_d;
				low_head_q <= low_head_d;
				high_fill_q <= high_fill_d;
				low_fill_q <= low_fill_d;
				tick_q <= tick_new;
				req_q <= req_new;
				refused_q <= sat_add32(refused_q, refused_inc);
				if (kind_d == KIND_HIGH) begin
					high_srv_q <= sat_add32(high_srv_q, 32'd1);
					high_wsum_q <= sat_add32(high_wsum_q, wait_d);
				end else if (kind_d == KIND_LOW) begin
					low_srv_q <= sat_add32(low_srv_q, 32'd1);
					low_wsum_q <= sat_add32(low_wsum_q, wait_d);
				end else begin
					idle_q <= sat_add32(idle_q, 32'd1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			kind_q <= kind_d;
			id_q <= id_d;
			wait_q <= wait_d;
			high_queued_q <= 3'(32'(high_fill_d));
			low_queued_q <= 3'(32'(low_fill_d));
		end
	end

	assign done = done_q;
	assign served_kind = kind_q;
	assign served_id = id_q;
	assign served_wait = wait_q;
	assign total_requests = req_q;
	assign high_served_count = high_srv_q;
	assign low_served_count = low_srv_q;
	assign refused_count = refused_q;
	assign idle_count = idle_q;
	assign high_wait_sum = high_wsum_q;
	assign low_wait_sum = low_wsum_q;
	assign high_queued = high_queued_q;
	assign low_queued = low_queued_q;

endmodule
